[src/positional_list_engine_unit_defines.svh]
// Assertion macros used by the positional list engine top level.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk and disabled during rst.
`define PLE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list engine check failed");
// Next-cycle implication, sampled on clk and disabled during rst.
`define PLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list engine check failed");
`else
`define PLE_ASSERT_IMPL(label, ante, cons)
`define PLE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[src/ple_pkg.sv]
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

  localparam int POS_W         = 5;
  localparam int VAL_W         = 32;
  localparam int CNT_W         = 5;
  localparam int OP_W          = 2;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Command broadcast to every cell of the list.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } cell_cmd_t;

endpackage

[src/ple_req_if.sv]
// Request channel: operation, position and value with valid/ready.
`timescale 1ns / 1ps
interface ple_req_if;
  import ple_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value_in;

  modport source(output valid, op, position, value_in, input ready);
  modport sink(input valid, op, position, value_in, output ready);
endinterface

[src/ple_rsp_if.sv]
// Response channel: status, read value and count with valid/ready.
`timescale 1ns / 1ps
interface ple_rsp_if;
  import ple_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic signed [VAL_W-1:0] value_out;
  logic [CNT_W-1:0]        count;

  modport source(output valid, ok, value_out, count, input ready);
  modport sink(input valid, ok, value_out, count, output ready);
endinterface

[src/ple_cell.sv]
// One list slot: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps
module ple_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 4
) (
  input  logic                           clk,
  input  ple_pkg::cell_cmd_t             cmd,
  input  logic signed [ple_pkg::VAL_W-1:0] left,
  input  logic signed [ple_pkg::VAL_W-1:0] right,
  output logic signed [ple_pkg::VAL_W-1:0] entry,
  output logic signed [ple_pkg::VAL_W-1:0] rd
);
  import ple_pkg::*;

  localparam int CW = (IW > POS_W) ? IW : POS_W;
  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic [CW-1:0] pos_c;
  logic          hit;

  assign pos_c = CW'(cmd.pos);
  assign hit   = (IDX == pos_c);

  // Insert moves slots above the position up; remove pulls slots at or above it down.
  always_ff @(posedge clk) begin
    if (cmd.ins && (IDX > pos_c)) begin
      entry <= left;
    end else if (cmd.ins && hit) begin
      entry <= cmd.val;
    end else if (cmd.rem && (IDX >= pos_c)) begin
      entry <= right;
    end
  end

  assign rd = hit ? entry : '0;
endmodule

[src/positional_list_engine_unit.sv]
// Top level of the positional list engine: cell row, count and response register.
// Latency: the response of a request is valid in the cycle after its request beat.
// Throughput: one request per cycle, as long as requests are taken.
// A request is taken whenever the response register is empty or being drained.
// Reset clears the entry count and the response valid; cell contents stay undefined.
`timescale 1ns / 1ps
`include "positional_list_engine_unit_defines.svh"
module positional_list_engine_unit #(
  parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  ple_req_if.sink    req,
  ple_rsp_if.source  rsp
);
  import ple_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_next;
  logic [CMPW-1:0]         pos_x;
  logic [CMPW-1:0]         cnt_x;
  logic                    accept;
  logic                    ins_ok;
  logic                    rem_ok;
  logic                    rd_ok;
  logic                    op_ok;
  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] entry [DEPTH];
  logic signed [VAL_W-1:0] rd    [DEPTH];
  logic signed [VAL_W-1:0] rd_any;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign pos_x  = CMPW'(req.position);
  assign cnt_x  = CMPW'(count_r);
  assign ins_ok = (req.op == OP_INSERT) && (pos_x <= cnt_x) && (cnt_x < CMPW'(DEPTH));
  assign rem_ok = (req.op == OP_REMOVE) && (pos_x < cnt_x);
  assign rd_ok  = (req.op == OP_READ) && (pos_x < cnt_x);
  assign op_ok  = ins_ok || rem_ok || rd_ok || (req.op == OP_CLEAR);

  assign cmd.ins = accept && ins_ok;
  assign cmd.rem = accept && rem_ok;
  assign cmd.pos = req.position;
  assign cmd.val = req.value_in;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = entry[g+1];
    end
    ple_cell #(
      .INDEX(g),
      .IW   (IW)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .left (left_v),
      .right(right_v),
      .entry(entry[g]),
      .rd   (rd[g])
    );
  end

  // Only the addressed cell drives a nonzero read value, so an OR merges them.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | rd[i];
    end
  end

  always_comb begin
    count_next = count_r;
    if (accept) begin
      unique case (op_t'(req.op))
        OP_INSERT: if (ins_ok) count_next = count_r + CW'(1);
        OP_REMOVE: if (rem_ok) count_next = count_r - CW'(1);
        OP_READ:   count_next = count_r;
        OP_CLEAR:  count_next = '0;
        default:   count_next = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_r   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count_r <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.ok        <= op_ok;
      rsp.value_out <= rd_ok ? rd_any : '0;
      rsp.count     <= CNT_W'(count_next);
    end
  end

  `PLE_ASSERT_IMPL(a_count_bound, 1'b1, cnt_x <= CMPW'(DEPTH))
  `PLE_ASSERT_NEXT(a_clear_empties, accept && (req.op == OP_CLEAR), (count_r == '0) && rsp.ok)
  `PLE_ASSERT_NEXT(a_refuse_holds, accept && !op_ok, $stable(count_r) && !rsp.ok)
  `PLE_ASSERT_NEXT(a_insert_grows, cmd.ins, count_r == $past(count_r) + CW'(1))
endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the positional list engine: directed and random requests.
`timescale 1ns / 1ps
module tb;
  import ple_pkg::*;

  localparam int LIST_DEPTH    = 16;
  localparam int RANDOM_ITEMS  = 900;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int TAIL_CYCLES   = 16;
  localparam int IDLE_PERCENT  = 32;

  typedef struct {
    op_t                     op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
    bit                      hold_for_drain;
    bit                      steady;
  } list_req_t;

  typedef struct {
    logic                    ok;
    logic signed [VAL_W-1:0] value_out;
    logic [CNT_W-1:0]        count;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine_unit #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the list that the predictor keeps in step with the block.
  logic signed [VAL_W-1:0] list_cells [LIST_DEPTH];
  int                      list_count = 0;

  list_req_t request_q [$];
  list_rsp_t awaited_rsp_q [$];
  list_req_t launch_req;
  list_rsp_t want_rsp;

  bit req_fired   = 1'b0;
  bit steady_run  = 1'b0;
  int cycle_count = 0;
  int accepted    = 0;
  int total_reqs  = 0;
  int responses   = 0;
  int mismatches  = 0;
  int refused     = 0;
  int peak_count  = 0;
  int ops_ok [4]  = '{0, 0, 0, 0};
  int plan_count  = 0;

  function automatic list_rsp_t serve_request(op_t op, logic [POS_W-1:0] pos,
                                              logic signed [VAL_W-1:0] val);
    list_rsp_t r;
    int i;
    r.ok = 1'b0;
    r.value_out = '0;
    case (op)
      OP_INSERT: begin
        if (pos <= list_count && list_count < LIST_DEPTH) begin
          for (i = list_count; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = val;
          list_count++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < list_count) begin
          for (i = pos; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
          list_count--;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (pos < list_count) begin
          r.value_out = list_cells[pos];
          r.ok = 1'b1;
        end
      end
      default: begin
        list_count = 0;
        r.ok = 1'b1;
      end
    endcase
    r.count = list_count[CNT_W-1:0];
    return r;
  endfunction

  // The generator tracks only the count so it can aim positions at live entries.
  task automatic queue_request(op_t op, int pos, logic signed [VAL_W-1:0] val);
    list_req_t item;
    item.op = op;
    item.position = pos[POS_W-1:0];
    item.value_in = val;
    item.hold_for_drain = 1'b0;
    item.steady = 1'b0;
    request_q.push_back(item);
    case (op)
      OP_INSERT: if (pos <= plan_count && plan_count < LIST_DEPTH) plan_count++;
      OP_REMOVE: if (pos < plan_count) plan_count--;
      OP_CLEAR:  plan_count = 0;
      default: ;
    endcase
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) return 32'sh8000_0000;
    if (k < 6) return 32'sh7fff_ffff;
    if (k < 8) return 32'sd0;
    if (k < 10) return -32'sd1;
    return $urandom;
  endfunction

  // Driver: a beat stays on the bus until taken, then the next one may follow.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
      if (!req_ch.valid || req_fired) begin
        if (request_q.size() != 0 &&
            !(request_q[0].hold_for_drain && awaited_rsp_q.size() != 0) &&
            (request_q[0].steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          launch_req = request_q.pop_front();
          steady_run <= launch_req.steady;
          req_ch.valid <= 1'b1;
          req_ch.op <= launch_req.op;
          req_ch.position <= launch_req.position;
          req_ch.value_in <= launch_req.value_in;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each response beat, then predicts from each request beat.
  always @(posedge clk) begin
    if (rst) begin
      req_fired = 1'b0;
    end else begin
      cycle_count++;
      if (rsp_ch.valid && rsp_ch.ready) begin
        responses++;
        if (awaited_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Response beat %0d arrived with none expected: ok=%0b value=%0d count=%0d",
                     responses, rsp_ch.ok, rsp_ch.value_out, rsp_ch.count);
        end else begin
          want_rsp = awaited_rsp_q.pop_front();
          if (rsp_ch.ok !== want_rsp.ok || rsp_ch.value_out !== want_rsp.value_out ||
              rsp_ch.count !== want_rsp.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Response beat %0d: expected ok=%0b value=%0d count=%0d, got ok=%0b value=%0d count=%0d",
                       responses, want_rsp.ok, want_rsp.value_out, want_rsp.count,
                       rsp_ch.ok, rsp_ch.value_out, rsp_ch.count);
          end
        end
      end
      req_fired = req_ch.valid && req_ch.ready;
      if (req_fired) begin
        want_rsp = serve_request(op_t'(req_ch.op), req_ch.position, req_ch.value_in);
        awaited_rsp_q.push_back(want_rsp);
        accepted++;
        if (want_rsp.ok) ops_ok[req_ch.op]++;
        else refused++;
        if (list_count > peak_count) peak_count = list_count;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d of %0d requests taken", cycle_count,
             accepted, total_reqs);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int directed_n;
    int sel;
    int k;
    int pos;
    op_t op;

    req_ch.valid = 1'b0;
    req_ch.op = OP_INSERT;
    req_ch.position = '0;
    req_ch.value_in = '0;
    rsp_ch.ready = 1'b0;

    // Refusals on an empty list, including an insert past the end, and a clear of the empty list.
    queue_request(OP_READ, 0, 32'sd5);
    queue_request(OP_REMOVE, 0, -32'sd5);
    queue_request(OP_CLEAR, 0, 32'sd0);
    queue_request(OP_INSERT, 1, 32'sd9);
    // Extreme values at the front, back and middle, then reads, removes and clears, in and out of range.
    queue_request(OP_INSERT, 0, 32'sh8000_0000);
    queue_request(OP_INSERT, 1, 32'sh7fff_ffff);
    queue_request(OP_INSERT, 0, -32'sd1);
    queue_request(OP_INSERT, 1, 32'sd0);
    queue_request(OP_INSERT, 4, 32'sh5a5a_a5a5);
    queue_request(OP_READ, 0, 32'sd0);
    queue_request(OP_READ, 2, 32'sd0);
    queue_request(OP_READ, 4, 32'sd0);
    queue_request(OP_READ, 5, 32'sd0);
    queue_request(OP_READ, 31, 32'sh7fff_ffff);
    queue_request(OP_INSERT, 31, 32'sd7);
    queue_request(OP_INSERT, 6, 32'sd7);
    queue_request(OP_REMOVE, 16, 32'sd0);
    queue_request(OP_REMOVE, 5, 32'sd0);
    queue_request(OP_REMOVE, 4, 32'sd0);
    queue_request(OP_REMOVE, 0, 32'sd0);
    queue_request(OP_READ, 1, 32'sd0);
    queue_request(OP_CLEAR, 0, 32'sd0);
    queue_request(OP_CLEAR, 0, -32'sd1);
    directed_n = request_q.size();

    while (request_q.size() < directed_n + RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        // Fill to capacity, then push against the full list.
        while (plan_count < LIST_DEPTH)
          queue_request(OP_INSERT, $urandom_range(0, plan_count), pick_value());
        repeat ($urandom_range(1, 3))
          queue_request(OP_INSERT, $urandom_range(0, LIST_DEPTH), pick_value());
        repeat ($urandom_range(2, 6))
          queue_request(OP_READ, $urandom_range(0, LIST_DEPTH - 1), pick_value());
      end else if (sel < 75) begin
        k = $urandom_range(0, 99);
        if (k < 38) op = OP_INSERT;
        else if (k < 63) op = OP_REMOVE;
        else if (k < 96) op = OP_READ;
        else op = OP_CLEAR;
        if (op == OP_INSERT) pos = $urandom_range(0, plan_count);
        else if (plan_count > 0) pos = $urandom_range(0, plan_count - 1);
        else pos = 0;
        queue_request(op, pos, pick_value());
      end else begin
        op = op_t'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) pos = plan_count;
        else pos = $urandom_range(0, 31);
        queue_request(op, pos, pick_value());
      end
    end

    request_q[directed_n + 300].hold_for_drain = 1'b1;
    request_q[directed_n + 650].hold_for_drain = 1'b1;
    for (k = directed_n + 450; k < directed_n + 600; k++) request_q[k].steady = 1'b1;
    total_reqs = request_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted < total_reqs || awaited_rsp_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d requests in %0d cycles: %0d refused, list filled up to %0d entries.",
             accepted, cycle_count, refused, peak_count);
    $display("Accepted %0d inserts, %0d removes, %0d reads and %0d clears; %0d mismatches.",
             ops_ok[OP_INSERT], ops_ok[OP_REMOVE], ops_ok[OP_READ], ops_ok[OP_CLEAR],
             mismatches);
    if (mismatches == 0 && awaited_rsp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
